@@ sv/pca_pkg.sv @@
package pca_pkg;

  localparam int MAX_CONSUMERS = 16;
  localparam int IDX_W = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
  localparam int CNT_W = $clog2(MAX_CONSUMERS + 1);
  // active draws plus baseline, before saturation
  localparam int SUM_W = $clog2((MAX_CONSUMERS + 1) * 65536);

  localparam int DRAW_W    = 16;
  localparam int CHARGE_W  = 48;
  localparam int RUNTIME_W = 22;
  localparam int MUL_W     = 32;
  // mah * pct * 60 and 100 * draw
  localparam int NUM_W = 29;
  localparam int DEN_W = 23;

  localparam logic [DRAW_W-1:0]    DRAW_MAX    = 16'hFFFF;
  localparam logic [NUM_W-1:0]     RUNTIME_MAX = 29'd4194303;
  localparam logic [DRAW_W-1:0]    BASELINE_RST    = 16'd40;
  localparam logic [DRAW_W-1:0]    MAX_ELAPSED_RST = 16'd10000;

  localparam logic [2:0] CMD_REGISTER   = 3'd0;
  localparam logic [2:0] CMD_SET_DRAW   = 3'd1;
  localparam logic [2:0] CMD_SET_ACTIVE = 3'd2;
  localparam logic [2:0] CMD_TICK       = 3'd3;
  localparam logic [2:0] CMD_RESET_CHG  = 3'd4;
  localparam logic [2:0] CMD_QUERY      = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

  localparam logic CFG_BASELINE    = 1'b0;
  localparam logic CFG_MAX_ELAPSED = 1'b1;

endpackage

@@ sv/pca_div.sv @@
module pca_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pca_pkg::NUM_W-1:0]   num,
  input  logic [pca_pkg::DEN_W-1:0]   den,
  output logic                        done,
  output logic [pca_pkg::NUM_W-1:0]   quo
);

  localparam int NUM_W = pca_pkg::NUM_W;
  localparam int DEN_W = pca_pkg::DEN_W;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   step_r;
  logic [DEN_W:0]      rem_r;
  logic [NUM_W-1:0]    quo_r;
  logic [DEN_W-1:0]    den_r;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W+1:0]    diff;

  // numerator shifts out of the top of quo_r while quotient bits enter below
  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(NUM_W);
      end else if (busy_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (busy_r) begin
      if (!diff[DEN_W+1]) begin
        rem_r <= diff[DEN_W:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ sv/power_consumption_accumulator.sv @@
// power consumption accumulator
// input channel (in_valid/in_ready) takes one command per transfer: register a
// consumer, set its draw or active bit, tick (charge += total draw * clamped ms),
// clear the charge, or query the runtime estimate. every command gives exactly
// one result on the out_ channel with status, total draw, charge and counts.
// the cfg_ channel writes baseline_ma (index 0) and max_elapsed_ms (index 1);
// it is ready outside reset and should be written only while the block is idle.
// one command at a time: in_ready is high only when the sequencer is idle.
// path from accept to out_valid: execute, then a walk of the registered
// entries through the draw and active memories, one entry a cycle, with a
// wait for the last read to land; then done. a tick passes a multiply and an
// add state; a query passes a multiply state and, when mah, pct and total
// draw are all nonzero, the 29-step restoring divider. in_ready returns the
// cycle after the result is loaded.
// a finished result sits in the output register; the next command may be
// accepted while it waits, but its own result holds until out_ready frees it.
// reset (rst_n low, synchronous) empties the table, zeroes the charge and
// loads baseline 40 mA and a 10000 ms clamp; table entries need no clearing
// since only registered entries are ever summed.
module power_consumption_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_consumer_index,
  input  logic [15:0] in_draw_ma,
  input  logic        in_active_flag,
  input  logic [15:0] in_elapsed_ms,
  input  logic [15:0] in_battery_mah,
  input  logic [6:0]  in_battery_pct,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_assigned_index,
  output logic [15:0] out_total_draw_ma,
  output logic [47:0] out_consumed_charge,
  output logic [21:0] out_runtime_min,
  output logic        out_runtime_valid,
  output logic [4:0]  out_powered_count,
  output logic [4:0]  out_consumer_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int MAXC  = pca_pkg::MAX_CONSUMERS;
  localparam int IDX_W = pca_pkg::IDX_W;
  localparam int CNT_W = pca_pkg::CNT_W;
  localparam int SUM_W = pca_pkg::SUM_W;
  localparam int MUL_W = pca_pkg::MUL_W;
  localparam int NUM_W = pca_pkg::NUM_W;
  localparam int DEN_W = pca_pkg::DEN_W;
  localparam int CMP_W = 32;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_ADD   = 3'd4;
  localparam logic [2:0] S_DIVST = 3'd5;
  localparam logic [2:0] S_DIV   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]  state_r, state_nxt;

  // latched command
  logic [2:0]  cmd_r;
  logic [3:0]  idx_r;
  logic [15:0] draw_r;
  logic        act_r;
  logic [15:0] elapsed_r;
  logic [15:0] mah_r;
  logic [6:0]  pct_r;

  logic [CNT_W-1:0]    cnt_r;
  logic [47:0]         charge_r;
  logic [15:0]         baseline_r;
  logic [15:0]         max_el_r;

  logic [CNT_W-1:0]    scan_r;
  logic                rd_pend_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CNT_W-1:0]    act_cnt_r;
  logic [15:0]         total_r;
  logic [1:0]          status_r;
  logic [3:0]          assigned_r;
  logic [MUL_W-1:0]    mul_r;
  logic [21:0]         runtime_r;
  logic                rt_valid_r;

  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [3:0]          out_assigned_r;
  logic [15:0]         out_total_r;
  logic [47:0]         out_charge_r;
  logic [21:0]         out_runtime_r;
  logic                out_rt_valid_r;
  logic [4:0]          out_act_cnt_r;
  logic [4:0]          out_cnt_r;

  // state memories
  logic [15:0] draw_mem [MAXC];
  logic        act_mem  [MAXC];
  logic [15:0] draw_rd_r;
  logic        act_rd_r;

  logic             reg_ok, idx_ok;
  logic             draw_we, act_we, act_wdata;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic             scan_end;
  logic [15:0]      ms_clamped;
  logic             query_ok;
  logic [48:0]      charge_sum;
  logic [NUM_W-1:0] mp_ext, div_num, div_quo;
  logic [DEN_W-1:0] tot_ext, div_den;
  logic             div_start, div_done;
  logic             out_load;

  assign reg_ok = CMP_W'(cnt_r) < CMP_W'(MAXC);
  assign idx_ok = CMP_W'(idx_r) < CMP_W'(cnt_r);

  assign draw_we = (state_r == S_EXEC) &&
                   (((cmd_r == pca_pkg::CMD_REGISTER) && reg_ok) ||
                    ((cmd_r == pca_pkg::CMD_SET_DRAW) && idx_ok));
  assign act_we = (state_r == S_EXEC) &&
                  (((cmd_r == pca_pkg::CMD_REGISTER) && reg_ok) ||
                   ((cmd_r == pca_pkg::CMD_SET_ACTIVE) && idx_ok));
  assign wr_addr = (cmd_r == pca_pkg::CMD_REGISTER) ? cnt_r[IDX_W-1:0] : IDX_W'(idx_r);
  // a new entry starts inactive
  assign act_wdata = (cmd_r == pca_pkg::CMD_REGISTER) ? 1'b0 : act_r;
  assign rd_addr = scan_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (draw_we) begin
      draw_mem[wr_addr] <= draw_r;
    end
    if (act_we) begin
      act_mem[wr_addr] <= act_wdata;
    end
    draw_rd_r <= draw_mem[rd_addr];
    act_rd_r  <= act_mem[rd_addr];
  end

  assign scan_end   = !rd_pend_r && (scan_r >= cnt_r);
  assign ms_clamped = (elapsed_r > max_el_r) ? max_el_r : elapsed_r;
  assign query_ok   = (mah_r != 16'd0) && (pct_r != 7'd0) && (total_r != 16'd0);
  assign charge_sum = {1'b0, charge_r} + 49'(mul_r);

  // times 60 by shift and subtract, times 100 by shift and add
  assign mp_ext  = NUM_W'(mul_r[22:0]);
  assign div_num = (mp_ext << 6) - (mp_ext << 2);
  assign tot_ext = DEN_W'(total_r);
  assign div_den = (tot_ext << 6) + (tot_ext << 5) + (tot_ext << 2);
  assign div_start = (state_r == S_DIVST);

  pca_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          if ((cmd_r == pca_pkg::CMD_TICK) || (cmd_r == pca_pkg::CMD_QUERY)) begin
            state_nxt = S_MUL;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_MUL: begin
        if (cmd_r == pca_pkg::CMD_TICK) begin
          state_nxt = S_ADD;
        end else if (query_ok) begin
          state_nxt = S_DIVST;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_ADD:   state_nxt = S_DONE;
      S_DIVST: state_nxt = S_DIV;
      S_DIV: begin
        if (div_done) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      charge_r    <= '0;
      baseline_r  <= pca_pkg::BASELINE_RST;
      max_el_r    <= pca_pkg::MAX_ELAPSED_RST;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          pca_pkg::CFG_BASELINE:    baseline_r <= cfg_data;
          pca_pkg::CFG_MAX_ELAPSED: max_el_r   <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == S_EXEC) begin
        rd_pend_r <= 1'b0;
        if ((cmd_r == pca_pkg::CMD_REGISTER) && reg_ok) begin
          cnt_r <= cnt_r + 1'b1;
        end
        if (cmd_r == pca_pkg::CMD_RESET_CHG) begin
          charge_r <= '0;
        end
      end
      if (state_r == S_SCAN) begin
        rd_pend_r <= (scan_r < cnt_r);
      end
      if (state_r == S_ADD) begin
        charge_r <= charge_sum[48] ? '1 : charge_sum[47:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      cmd_r     <= in_command;
      idx_r     <= in_consumer_index;
      draw_r    <= in_draw_ma;
      act_r     <= in_active_flag;
      elapsed_r <= in_elapsed_ms;
      mah_r     <= in_battery_mah;
      pct_r     <= in_battery_pct;
    end
    case (state_r)
      S_EXEC: begin
        status_r   <= pca_pkg::STATUS_OK;
        assigned_r <= '0;
        runtime_r  <= '0;
        rt_valid_r <= 1'b0;
        scan_r     <= '0;
        sum_r      <= SUM_W'(baseline_r);
        act_cnt_r  <= '0;
        case (cmd_r)
          pca_pkg::CMD_REGISTER: begin
            if (reg_ok) begin
              assigned_r <= 4'(cnt_r);
            end else begin
              status_r <= pca_pkg::STATUS_FULL;
            end
          end
          pca_pkg::CMD_SET_DRAW, pca_pkg::CMD_SET_ACTIVE: begin
            if (!idx_ok) status_r <= pca_pkg::STATUS_BAD_INDEX;
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        // each read is issued, then summed in the cycle after
        if (rd_pend_r && act_rd_r) begin
          sum_r     <= sum_r + SUM_W'(draw_rd_r);
          act_cnt_r <= act_cnt_r + 1'b1;
        end
        if (scan_r < cnt_r) begin
          scan_r <= scan_r + 1'b1;
        end
        if (scan_end) begin
          total_r <= (sum_r > SUM_W'(pca_pkg::DRAW_MAX)) ? pca_pkg::DRAW_MAX : sum_r[15:0];
        end
      end
      S_MUL: begin
        if (cmd_r == pca_pkg::CMD_TICK) begin
          mul_r <= MUL_W'(total_r) * MUL_W'(ms_clamped);
        end else begin
          mul_r <= MUL_W'(mah_r) * MUL_W'(pct_r);
        end
      end
      S_DIV: begin
        if (div_done) begin
          runtime_r  <= (div_quo > pca_pkg::RUNTIME_MAX) ? pca_pkg::RUNTIME_MAX[21:0]
                                                           : div_quo[21:0];
          rt_valid_r <= 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_status_r   <= status_r;
      out_assigned_r <= assigned_r;
      out_total_r    <= total_r;
      out_charge_r   <= charge_r;
      out_runtime_r  <= runtime_r;
      out_rt_valid_r <= rt_valid_r;
      out_act_cnt_r  <= 5'(act_cnt_r);
      out_cnt_r      <= 5'(cnt_r);
    end
  end

  // nothing is taken while reset holds
  assign in_ready  = rst_n && (state_r == S_IDLE);
  assign cfg_ready = rst_n;

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_assigned_index  = out_assigned_r;
  assign out_total_draw_ma   = out_total_r;
  assign out_consumed_charge = out_charge_r;
  assign out_runtime_min     = out_runtime_r;
  assign out_runtime_valid   = out_rt_valid_r;
  assign out_powered_count   = out_act_cnt_r;
  assign out_consumer_count  = out_cnt_r;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(cnt_r) <= CMP_W'(MAXC))
    else $error("consumer count above table size");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_EXEC)
    else $error("accepted command did not start");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  a_rd_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> state_r == S_SCAN)
    else $error("table read pending outside the walk");

  a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV)
    else $error("divider finished while not awaited");
`endif

endmodule

@@ test/power_consumption_accumulator_tb.sv @@
`timescale 1ns / 1ps

module power_consumption_accumulator_tb;

  localparam int DRAIN_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam longint unsigned CHARGE_CAP = 64'h0000_FFFF_FFFF_FFFF;
  localparam longint unsigned RUNTIME_CAP = 64'd4194303;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  idx;
    logic [15:0] draw;
    logic        act;
    logic [15:0] elapsed;
    logic [15:0] mah;
    logic [6:0]  pct;
  } cmd_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  assigned;
    logic [15:0] total;
    logic [47:0] charge;
    logic [21:0] runtime;
    logic        rt_valid;
    logic [4:0]  act_cnt;
    logic [4:0]  reg_cnt;
  } acct_report_t;

  typedef struct packed {
    bit           is_cfg;
    cmd_item_t    item;
    logic [15:0]  base;
    logic [15:0]  clamp;
    bit           typed;
    acct_report_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [3:0]  in_consumer_index = '0;
  logic [15:0] in_draw_ma = '0;
  logic        in_active_flag = 1'b0;
  logic [15:0] in_elapsed_ms = '0;
  logic [15:0] in_battery_mah = '0;
  logic [6:0]  in_battery_pct = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_assigned_index;
  logic [15:0] out_total_draw_ma;
  logic [47:0] out_consumed_charge;
  logic [21:0] out_runtime_min;
  logic        out_runtime_valid;
  logic [4:0]  out_powered_count;
  logic [4:0]  out_consumer_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  power_consumption_accumulator dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_consumer_index   (in_consumer_index),
    .in_draw_ma          (in_draw_ma),
    .in_active_flag      (in_active_flag),
    .in_elapsed_ms       (in_elapsed_ms),
    .in_battery_mah      (in_battery_mah),
    .in_battery_pct      (in_battery_pct),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_assigned_index  (out_assigned_index),
    .out_total_draw_ma   (out_total_draw_ma),
    .out_consumed_charge (out_consumed_charge),
    .out_runtime_min     (out_runtime_min),
    .out_runtime_valid   (out_runtime_valid),
    .out_powered_count   (out_powered_count),
    .out_consumer_count  (out_consumer_count),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // mirror of the consumer table, charge and settings
  logic [15:0]     draw_mem [pca_pkg::MAX_CONSUMERS];
  bit              on_mem [pca_pkg::MAX_CONSUMERS];
  int unsigned     n_reg = 0;
  longint unsigned charge_acc = 0;
  longint unsigned base_ma = 40;
  longint unsigned clamp_ms = 10000;

  acct_report_t due_reports[$];
  dir_row_t     dir_tab[$];
  int           mismatches = 0;
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           phase_no = -1;
  int           hold_left = 0;
  bit           hold_done = 1'b0;

  function automatic longint unsigned draw_total();
    longint unsigned sum;
    sum = base_ma;
    for (int i = 0; i < n_reg; i++) begin
      if (on_mem[i]) sum += 64'(draw_mem[i]);
    end
    return (sum > 65535) ? 65535 : sum;
  endfunction

  function automatic int unsigned active_total();
    int unsigned n;
    n = 0;
    for (int i = 0; i < n_reg; i++) n += 32'(on_mem[i]);
    return n;
  endfunction

  function automatic acct_report_t apply_command(input cmd_item_t it);
    acct_report_t    r;
    longint unsigned ms, add, d, rt;
    r = '0;
    case (it.cmd)
      pca_pkg::CMD_REGISTER: begin
        if (n_reg >= pca_pkg::MAX_CONSUMERS) begin
          r.status = pca_pkg::STATUS_FULL;
        end else begin
          draw_mem[n_reg] = it.draw;
          on_mem[n_reg] = 1'b0;
          r.assigned = 4'(n_reg);
          n_reg++;
        end
      end
      pca_pkg::CMD_SET_DRAW, pca_pkg::CMD_SET_ACTIVE: begin
        if (32'(it.idx) >= n_reg) r.status = pca_pkg::STATUS_BAD_INDEX;
        else if (it.cmd == pca_pkg::CMD_SET_DRAW) draw_mem[it.idx] = it.draw;
        else on_mem[it.idx] = it.act;
      end
      pca_pkg::CMD_TICK: begin
        ms = (64'(it.elapsed) > clamp_ms) ? clamp_ms : 64'(it.elapsed);
        add = draw_total() * ms;
        if (add > CHARGE_CAP - charge_acc) charge_acc = CHARGE_CAP;
        else charge_acc += add;
      end
      pca_pkg::CMD_RESET_CHG: charge_acc = 0;
      pca_pkg::CMD_QUERY: begin
        d = draw_total();
        if (it.mah != 0 && it.pct != 0 && d != 0) begin
          rt = (64'(it.mah) * 64'(it.pct) * 64'd60) / (64'd100 * d);
          r.runtime = 22'((rt > RUNTIME_CAP) ? RUNTIME_CAP : rt);
          r.rt_valid = 1'b1;
        end
      end
      default: ;
    endcase
    r.total = 16'(draw_total());
    r.charge = 48'(charge_acc);
    r.act_cnt = 5'(active_total());
    r.reg_cnt = 5'(n_reg);
    return r;
  endfunction

  function automatic cmd_item_t mk_item(input logic [2:0] cmd, input logic [3:0] idx,
                                        input logic [15:0] draw, input logic act,
                                        input logic [15:0] elapsed, input logic [15:0] mah,
                                        input logic [6:0] pct);
    cmd_item_t it;
    it.cmd = cmd;
    it.idx = idx;
    it.draw = draw;
    it.act = act;
    it.elapsed = elapsed;
    it.mah = mah;
    it.pct = pct;
    return it;
  endfunction

  function automatic acct_report_t mk_rep(input logic [1:0] status, input logic [15:0] total,
                                          input logic [47:0] charge, input logic [4:0] act_cnt,
                                          input logic [4:0] reg_cnt);
    acct_report_t r;
    r = '0;
    r.status = status;
    r.total = total;
    r.charge = charge;
    r.act_cnt = act_cnt;
    r.reg_cnt = reg_cnt;
    return r;
  endfunction

  function automatic dir_row_t cmd_row(input cmd_item_t it, input bit typed,
                                       input acct_report_t want);
    dir_row_t row;
    row = '0;
    row.item = it;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [15:0] base, input logic [15:0] clamp);
    dir_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.base = base;
    row.clamp = clamp;
    return row;
  endfunction

  function automatic cmd_item_t rand_item();
    cmd_item_t it;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) it.cmd = pca_pkg::CMD_REGISTER;
    else if (pick < 28) it.cmd = pca_pkg::CMD_SET_DRAW;
    else if (pick < 50) it.cmd = pca_pkg::CMD_SET_ACTIVE;
    else if (pick < 72) it.cmd = pca_pkg::CMD_TICK;
    else if (pick < 77) it.cmd = pca_pkg::CMD_RESET_CHG;
    else if (pick < 95) it.cmd = pca_pkg::CMD_QUERY;
    else it.cmd = 3'($urandom_range(7, 6));
    // mostly aim at registered entries so the table actually changes
    if (n_reg != 0 && $urandom_range(99) < 85) it.idx = 4'($urandom_range(n_reg - 1));
    else it.idx = 4'($urandom_range(15));
    it.draw = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000));
    it.act = 1'($urandom_range(1));
    it.elapsed = 16'($urandom_range(1) ? $urandom_range(65535) : $urandom_range(1000));
    it.mah = 16'($urandom_range(65535));
    it.pct = 7'(($urandom_range(99) < 85) ? $urandom_range(100) : $urandom_range(127));
    return it;
  endfunction

  task automatic flag_mismatch(input string field, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t: %s got %0d want %0d", $time, field, got, want);
    mismatches++;
  endtask

  task automatic check_report();
    acct_report_t want;
    if (due_reports.size() == 0) begin
      flag_mismatch("unexpected result, status", out_status, 0);
    end else begin
      want = due_reports.pop_front();
      if (out_status !== want.status) flag_mismatch("status", out_status, want.status);
      if (out_assigned_index !== want.assigned)
        flag_mismatch("assigned_index", out_assigned_index, want.assigned);
      if (out_total_draw_ma !== want.total)
        flag_mismatch("total_draw_ma", out_total_draw_ma, want.total);
      if (out_consumed_charge !== want.charge)
        flag_mismatch("consumed_charge", out_consumed_charge, want.charge);
      if (out_runtime_min !== want.runtime)
        flag_mismatch("runtime_min", out_runtime_min, want.runtime);
      if (out_runtime_valid !== want.rt_valid)
        flag_mismatch("runtime_valid", out_runtime_valid, want.rt_valid);
      if (out_powered_count !== want.act_cnt)
        flag_mismatch("powered_count", out_powered_count, want.act_cnt);
      if (out_consumer_count !== want.reg_cnt)
        flag_mismatch("consumer_count", out_consumer_count, want.reg_cnt);
    end
  endtask

  // result side: checks each transfer, then picks out_ready for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_report();
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ready <= 1'b0;
      end else if (phase_no == HOLD_PHASE && !hold_done) begin
        // long stall so the output register fills and the input backs up
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input cmd_item_t it, input bit typed, input acct_report_t want);
    acct_report_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= it.cmd;
    in_consumer_index <= it.idx;
    in_draw_ma <= it.draw;
    in_active_flag <= it.act;
    in_elapsed_ms <= it.elapsed;
    in_battery_mah <= it.mah;
    in_battery_pct <= it.pct;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = apply_command(it);
    due_reports.push_back(typed ? want : pred);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == pca_pkg::CFG_BASELINE) base_ma = 64'(val);
    else clamp_ms = 64'(val);
  endtask

  task automatic load_settings(input logic [15:0] base, input logic [15:0] clamp);
    settle();
    write_cfg(pca_pkg::CFG_BASELINE, base);
    write_cfg(pca_pkg::CFG_MAX_ELAPSED, clamp);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] b, m;
    int          ti, ri;
    for (int i = 0; i < pca_pkg::MAX_CONSUMERS; i++) begin
      draw_mem[i] = '0;
      on_mem[i] = 1'b0;
    end

    // reset settings: baseline 40 mA, 10000 ms clamp, empty table
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_DRAW, 0, 16'h1234, 0, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_BAD_INDEX, 40, 0, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_ACTIVE, 15, 0, 1, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_BAD_INDEX, 40, 0, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 0, 50), 1,
                              mk_rep(pca_pkg::STATUS_OK, 40, 0, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_TICK, 0, 0, 0, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 40, 0, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_TICK, 0, 0, 0, 16'hFFFF, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 40, 400000, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_RESET_CHG, 0, 0, 0, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 40, 0, 0, 0)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_REGISTER, 7, 16'hFFFF, 1, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 40, 0, 0, 1)));
    // 65535 + baseline saturates
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_ACTIVE, 0, 0, 1, 0, 0, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 16'hFFFF, 0, 1, 1)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 16'hFFFF, 100), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 16'hFFFF, 0), 1,
                              mk_rep(pca_pkg::STATUS_OK, 16'hFFFF, 0, 1, 1)));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 1, 1), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_TICK, 0, 0, 0, 16'hFFFF, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_REGISTER, 0, 1, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_DRAW, 1, 16'hAAAA, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_ACTIVE, 1, 0, 1, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_DRAW, 2, 16'h5555, 1, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(3'd6, 15, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 127),
                              0, '0));
    dir_tab.push_back(cmd_row(mk_item(3'd7, 15, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF, 127),
                              0, '0));
    // zero baseline and zero clamp: total can drop to nothing
    dir_tab.push_back(cfg_row(0, 0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_ACTIVE, 0, 0, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_SET_ACTIVE, 1, 0, 0, 0, 0, 0), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 16'hFFFF, 127), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_TICK, 0, 0, 0, 16'hFFFF, 0, 0), 0, '0));
    // one mA total with pct above 100 drives the runtime into saturation
    dir_tab.push_back(cfg_row(1, 16'hFFFF));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_QUERY, 0, 0, 0, 0, 16'hFFFF, 127), 0, '0));
    dir_tab.push_back(cmd_row(mk_item(pca_pkg::CMD_TICK, 0, 0, 0, 16'hFFFF, 0, 0), 0, '0));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 38;
    rx_idle_pct <= 45;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) load_settings(dir_tab[i].base, dir_tab[i].clamp);
      else send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin b = 40;     m = 10000;  ti = 38; ri = 45; end
        1: begin b = 0;      m = 0;      ti = 38; ri = 45; end
        2: begin b = 16'hFFFF; m = 16'hFFFF; ti = 45; ri = 38; end
        3: begin b = 1;      m = 1000;   ti = 45; ri = 38; end
        4: begin
          b = 16'($urandom_range(65535));
          m = 16'($urandom_range(65535));
          ti = 0;
          ri = 0;
        end
        default: begin b = 300; m = 16'hFFFF; ti = 0; ri = 0; end
      endcase
      load_settings(b, m);
      tx_idle_pct = ti;
      rx_idle_pct <= ri;
      phase_no <= p;
      repeat (ITEMS_PER_PHASE) send_item(rand_item(), 1'b0, '0);
    end

    settle();
    if (mismatches == 0) begin
      $display("power_consumption_accumulator: match");
    end else begin
      $display("power_consumption_accumulator: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("power_consumption_accumulator: mismatch");
    $finish;
  end

endmodule
